FILE: hw/rtl/mbw_pkg.sv
package mbw_pkg;

    localparam int unsigned HDR_LEN = 8;

    localparam logic [31:0] FCC_MOOF = 32'h6d6f_6f66;
    localparam logic [31:0] FCC_TRAF = 32'h7472_6166;
    localparam logic [31:0] FCC_MFHD = 32'h6d66_6864;
    localparam logic [31:0] FCC_TFHD = 32'h7466_6864;
    localparam logic [31:0] FCC_TRUN = 32'h7472_756e;
    localparam logic [31:0] FCC_UUID = 32'h7575_6964;
    localparam logic [31:0] FCC_MDAT = 32'h6d64_6174;

    typedef enum logic [1:0] {
        CLS_OTHER     = 2'd0,
        CLS_CONTAINER = 2'd1,
        CLS_LEAF      = 2'd2,
        CLS_MDAT      = 2'd3
    } t_class;

    typedef struct packed {
        logic [55:0] header_shift;
        logic [2:0]  header_count;
        logic        in_body;
        logic [31:0] body_left;
        t_class      current_class;
    } t_state;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic        in_header;
        logic        header_complete;
        logic [31:0] box_size;
        logic [31:0] box_type;
        t_class      type_class;
        logic        payload_byte;
        logic        box_end;
        logic        size_too_small;
    } t_result;

endpackage

FILE: hw/rtl/mbw_classify.sv
module mbw_classify
    import mbw_pkg::*;
(
    input  logic [31:0] i_type,
    output t_class      o_class
);

    always_comb begin
        if (i_type == FCC_MOOF || i_type == FCC_TRAF) begin
            o_class = CLS_CONTAINER;
        end else if (i_type == FCC_MFHD || i_type == FCC_TFHD ||
                     i_type == FCC_TRUN || i_type == FCC_UUID) begin
            o_class = CLS_LEAF;
        end else if (i_type == FCC_MDAT) begin
            o_class = CLS_MDAT;
        end else begin
            o_class = CLS_OTHER;
        end
    end

endmodule

FILE: hw/rtl/mbw_step.sv
module mbw_step
    import mbw_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    output t_state     o_state,
    output t_result    o_result
);

    localparam logic [31:0] HdrLen = 32'(HDR_LEN);

    logic [31:0] w_size;
    logic [31:0] w_type;
    t_class      w_class;
    logic        w_small;
    logic        w_empty;
    logic [31:0] w_left_dec;

    assign w_size     = i_state.header_shift[55:24];
    assign w_type     = {i_state.header_shift[23:0], i_byte};
    assign w_small    = w_size < HdrLen;
    assign w_empty    = w_small || (w_size == HdrLen);
    assign w_left_dec = i_state.body_left - 32'd1;

    mbw_classify u_classify (
        .i_type  (w_type),
        .o_class (w_class)
    );

    always_comb begin
        o_state                  = i_state;
        o_result                 = '0;
        o_result.byte_value      = i_byte;
        o_result.type_class      = CLS_OTHER;

        if (i_state.in_body && (i_state.body_left != 32'd0)) begin
            o_result.type_class   = i_state.current_class;
            o_result.payload_byte = (i_state.current_class == CLS_MDAT);
            o_state.body_left     = w_left_dec;
            if (w_left_dec == 32'd0) begin
                o_result.box_end = 1'b1;
                o_state.in_body  = 1'b0;
            end
        end else begin
            o_state.in_body    = 1'b0;
            o_result.in_header = 1'b1;
            if (i_state.header_count != 3'd7) begin
                o_state.header_shift = {i_state.header_shift[47:0], i_byte};
                o_state.header_count = i_state.header_count + 3'd1;
            end else begin
                o_result.header_complete = 1'b1;
                o_result.box_size        = w_size;
                o_result.box_type        = w_type;
                o_result.type_class      = w_class;
                o_state.current_class    = w_class;
                o_state.header_shift     = '0;
                o_state.header_count     = '0;
                if (w_class != CLS_CONTAINER) begin
                    o_result.size_too_small = w_small;
                    if (w_empty) begin
                        o_result.box_end = 1'b1;
                    end else begin
                        o_state.in_body   = 1'b1;
                        o_state.body_left = w_size - HdrLen;
                    end
                end
            end
        end
    end

endmodule

FILE: hw/rtl/mp4_box_stream_walker.sv
// An accepted word is held in the input register, then shown from the result register.
// Throughput: one byte per cycle while i_stall is low; the parser state updates once per
// byte as a word moves from the input register to the result register.
// Reset: synchronous, active low; clears the header gatherer, body counter, class
// and both valid flags. The block accepts words in the first cycle after reset.
module mp4_box_stream_walker
    import mbw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_body_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_byte_value,
    output logic        o_in_header,
    output logic        o_header_complete,
    output logic [31:0] o_box_size,
    output logic [31:0] o_box_type,
    output logic [1:0]  o_type_class,
    output logic        o_payload_byte,
    output logic        o_box_end,
    output logic        o_size_too_small
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    logic       w_advance;

    assign w_advance = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !w_advance;

    mbw_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_body_byte;
        end
        if (w_advance && r_in_valid) begin
            r_out <= n_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_byte_value      = r_out.byte_value;
    assign o_in_header       = r_out.in_header;
    assign o_header_complete = r_out.header_complete;
    assign o_box_size        = r_out.box_size;
    assign o_box_type        = r_out.box_type;
    assign o_type_class      = r_out.type_class;
    assign o_payload_byte    = r_out.payload_byte;
    assign o_box_end         = r_out.box_end;
    assign o_size_too_small  = r_out.size_too_small;

    a_small_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_size_too_small |-> o_header_complete && o_box_end)
        else $error("size_too_small without header completion and box end");

    a_payload_mdat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_payload_byte |-> !o_in_header && o_type_class == CLS_MDAT)
        else $error("payload byte outside mdat body");

    a_complete_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_header_complete |-> o_in_header)
        else $error("header completion on a body byte");

    a_count_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.in_body |-> r_state.header_count == 3'd0)
        else $error("header bytes gathered while skipping a body");

endmodule
